// ===== rtl/core/color_matrix_convert_macros.svh =====
// Assertion macros shared by the color matrix converter RTL.
`ifndef COLOR_MATRIX_CONVERT_MACROS_SVH
`define COLOR_MATRIX_CONVERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define CMC_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define CMC_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define CMC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== rtl/core/cmc_pkg.sv =====
// Types, constants and helpers of the color matrix converter.
package cmc_pkg;

    localparam int NCH          = 4;
    localparam int LANE_BITS    = 16;
    localparam int REG_BITS     = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int NARROW_BITS  = 8;
    localparam int FRAC_BITS    = 12;
    localparam int COUNT_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;

    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_COEFF_BITS = 16;

    localparam int ONE_Q = 1 << FRAC_BITS;

    // Full-scale factors for the constant term: 65535 in wide mode, 255.9 * 10 otherwise.
    localparam int K_WIDE   = 65535;
    localparam int K_NARROW = 2559;

    localparam int WIDE_LIMIT   = 65535 * ONE_Q;
    localparam int NARROW_LIMIT = 256 * 10 * ONE_Q;
    localparam int NARROW_SAT_X = 2559;
    localparam int NARROW_MAX   = 255;
    localparam int WIDE_MAX     = 65535;

    // Division by ten of values below 16384 as a multiply and shift.
    localparam int RECIP_TEN   = 3277;
    localparam int RECIP_BITS  = 12;
    localparam int RECIP_SHIFT = 15;
    localparam int Q_BITS      = SAMPLE_BITS + RECIP_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW3   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USED   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTCNT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE   = 3'd7;

    typedef struct packed {
        logic [NCH-1:0][REG_BITS-1:0] coeff_rows;
        logic [REG_BITS-1:0]          offset_weights;
        logic [COUNT_BITS-1:0]        used_channels;
        logic [COUNT_BITS-1:0]        out_count;
        logic                         wide_samples;
    } t_cfg;

    function automatic logic [COUNT_BITS-1:0] lim_count(
        input logic [COUNT_BITS-1:0] n,
        input logic [COUNT_BITS-1:0] cap
    );
        return (n > cap) ? cap : n;
    endfunction

endpackage

// ===== rtl/core/cmc_cfg.sv =====
// Configuration register file of the color matrix converter.
module cmc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [cmc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [cmc_pkg::REG_BITS-1:0]      i_cfg_wdata,
    output cmc_pkg::t_cfg                     o_cfg
);
    import cmc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NCH; j++) begin
                r_cfg.coeff_rows[j] <= REG_BITS'(ONE_Q) << (j * LANE_BITS);
            end
            r_cfg.offset_weights <= '0;
            r_cfg.used_channels  <= COUNT_BITS'(NCH);
            r_cfg.out_count      <= COUNT_BITS'(NCH);
            r_cfg.wide_samples   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ROW0:   r_cfg.coeff_rows[0]  <= i_cfg_wdata;
                CFG_ROW1:   r_cfg.coeff_rows[1]  <= i_cfg_wdata;
                CFG_ROW2:   r_cfg.coeff_rows[2]  <= i_cfg_wdata;
                CFG_ROW3:   r_cfg.coeff_rows[3]  <= i_cfg_wdata;
                CFG_OFFSET: r_cfg.offset_weights <= i_cfg_wdata;
                CFG_USED:   r_cfg.used_channels  <= i_cfg_wdata[COUNT_BITS-1:0];
                CFG_OUTCNT: r_cfg.out_count      <= i_cfg_wdata[COUNT_BITS-1:0];
                CFG_WIDE:   r_cfg.wide_samples   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/cmc_mac.sv =====
// Multiply stage and row summation stage of the color matrix converter.
`include "color_matrix_convert_macros.svh"

module cmc_mac #(
    parameter int CHANNELS   = cmc_pkg::DEF_CHANNELS,
    parameter int COEFF_BITS = cmc_pkg::DEF_COEFF_BITS,
    localparam int PW = COEFF_BITS + cmc_pkg::SAMPLE_BITS + 1,
    localparam int SW = PW + 2
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_en,
    input  cmc_pkg::t_cfg                                    i_cfg,
    input  logic                                             i_valid,
    input  logic [cmc_pkg::NCH-1:0][cmc_pkg::SAMPLE_BITS-1:0] i_samples,
    output logic                                             o_valid,
    output logic [cmc_pkg::NCH-1:0][SW-1:0]                  o_sum,
    output logic [cmc_pkg::NCH-1:0][PW-1:0]                  o_offp
);
    import cmc_pkg::*;

    localparam int CAP = (CHANNELS < NCH) ? CHANNELS : NCH;

    logic [COUNT_BITS-1:0]         w_nin;
    logic signed [SAMPLE_BITS:0]   w_samp [NCH];
    logic signed [COEFF_BITS-1:0]  w_coef [NCH][NCH];
    logic signed [COEFF_BITS-1:0]  w_off  [NCH];
    logic signed [SAMPLE_BITS:0]   w_k;
    logic signed [SW-1:0]          n_sum  [NCH];

    logic                          r_v1;
    logic signed [PW-1:0]          r_prod [NCH][NCH];
    logic signed [PW-1:0]          r_offp1 [NCH];
    logic                          r_v2;
    logic signed [SW-1:0]          r_sum  [NCH];
    logic signed [PW-1:0]          r_offp2 [NCH];

    assign w_nin = lim_count(i_cfg.used_channels, COUNT_BITS'(CAP));
    assign w_k   = i_cfg.wide_samples ? (SAMPLE_BITS + 1)'(K_WIDE)
                                      : (SAMPLE_BITS + 1)'(K_NARROW);

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            if (i >= int'(w_nin)) begin
                w_samp[i] = '0;
            end else if (i_cfg.wide_samples) begin
                w_samp[i] = (SAMPLE_BITS + 1)'(i_samples[i]);
            end else begin
                w_samp[i] = (SAMPLE_BITS + 1)'(i_samples[i][NARROW_BITS-1:0]);
            end
        end
        for (int j = 0; j < NCH; j++) begin
            w_off[j] = COEFF_BITS'(i_cfg.offset_weights >> (j * LANE_BITS));
            for (int i = 0; i < NCH; i++) begin
                w_coef[j][i] = COEFF_BITS'(i_cfg.coeff_rows[j] >> (i * LANE_BITS));
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            n_sum[j] = '0;
            for (int i = 0; i < NCH; i++) begin
                n_sum[j] = n_sum[j] + SW'(r_prod[j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NCH; j++) begin
                for (int i = 0; i < NCH; i++) begin
                    r_prod[j][i] <= w_coef[j][i] * w_samp[i];
                end
                r_offp1[j] <= w_off[j] * w_k;
                r_sum[j]   <= n_sum[j];
                r_offp2[j] <= r_offp1[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            o_sum[j]  = r_sum[j];
            o_offp[j] = r_offp2[j];
        end
    end

    assign o_valid = r_v2;

    `CMC_ASSERT_NEXT(a_mul_valid, i_clk, i_rst_n, i_en && i_valid, r_v1, "pixel lost in multiply stage")
    `CMC_ASSERT_NEXT(a_mul_hold, i_clk, i_rst_n, !i_en, $stable(r_v1) && $stable(r_v2), "pipe moved during stall")

endmodule

// ===== rtl/core/cmc_clamp.sv =====
// Offset, clamp and scaling stages of the color matrix converter.
`include "color_matrix_convert_macros.svh"

module cmc_clamp #(
    parameter int CHANNELS   = cmc_pkg::DEF_CHANNELS,
    parameter int COEFF_BITS = cmc_pkg::DEF_COEFF_BITS,
    localparam int PW = COEFF_BITS + cmc_pkg::SAMPLE_BITS + 1,
    localparam int SW = PW + 2
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_en,
    input  cmc_pkg::t_cfg                                    i_cfg,
    input  logic                                             i_valid,
    input  logic [cmc_pkg::NCH-1:0][SW-1:0]                  i_sum,
    input  logic [cmc_pkg::NCH-1:0][PW-1:0]                  i_offp,
    output logic                                             o_valid,
    output logic [cmc_pkg::NCH-1:0][cmc_pkg::SAMPLE_BITS-1:0] o_out
);
    import cmc_pkg::*;

    localparam int CAP = (CHANNELS < NCH) ? CHANNELS : NCH;
    localparam int AW  = SW + 5;

    logic [COUNT_BITS-1:0]    w_nout;
    logic signed [AW-1:0]     w_acc [NCH];
    logic [SAMPLE_BITS-1:0]   n_x   [NCH];
    logic [Q_BITS-1:0]        w_q   [NCH];
    logic [SAMPLE_BITS-1:0]   n_out [NCH];

    logic                     r_v3;
    logic [SAMPLE_BITS-1:0]   r_x   [NCH];
    logic                     r_v4;
    logic [SAMPLE_BITS-1:0]   r_out [NCH];

    assign w_nout = lim_count(i_cfg.out_count, COUNT_BITS'(CAP));

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            if (i_cfg.wide_samples) begin
                w_acc[j] = AW'($signed(i_sum[j])) + AW'($signed(i_offp[j]));
            end else begin
                w_acc[j] = (AW'($signed(i_sum[j])) <<< 3) + (AW'($signed(i_sum[j])) <<< 1)
                         + AW'($signed(i_offp[j]));
            end
            priority if (j >= int'(w_nout) || w_acc[j][AW-1]) begin
                n_x[j] = '0;
            end else if (i_cfg.wide_samples && w_acc[j] >= AW'(WIDE_LIMIT)) begin
                n_x[j] = SAMPLE_BITS'(WIDE_MAX);
            end else if (!i_cfg.wide_samples && w_acc[j] >= AW'(NARROW_LIMIT)) begin
                n_x[j] = SAMPLE_BITS'(NARROW_SAT_X);
            end else begin
                n_x[j] = w_acc[j][FRAC_BITS +: SAMPLE_BITS];
            end
        end
    end

    // In 8-bit mode the stored value is ten times the sum over 4096, to be divided by ten.
    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            w_q[j] = Q_BITS'(r_x[j]) * Q_BITS'(RECIP_TEN);
            if (i_cfg.wide_samples) begin
                n_out[j] = r_x[j];
            end else begin
                n_out[j] = SAMPLE_BITS'(w_q[j] >> RECIP_SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NCH; j++) begin
                r_x[j]   <= n_x[j];
                r_out[j] <= n_out[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            o_out[j] = r_out[j];
        end
    end

    assign o_valid = r_v4;

    for (genvar j = 0; j < NCH; j++) begin : g_chk
        `CMC_ASSERT_IMPLY(a_narrow_range, i_clk, i_rst_n, r_v4 && !i_cfg.wide_samples, r_out[j] <= SAMPLE_BITS'(NARROW_MAX), "8-bit result above 255")
        `CMC_ASSERT_IMPLY(a_unused_zero, i_clk, i_rst_n, r_v4 && (j >= int'(w_nout)), r_out[j] == '0, "unused channel not zero")
    end

endmodule

// ===== rtl/core/color_matrix_convert.sv =====
// Top level of the color matrix converter: 4x4 matrix with offset, one pixel per clock while the output is taken.
//
//  Channel   Handshake                        Payload
//  -------   ------------------------------   --------------------------------------------
//  in        i_in_valid / o_in_ready          i_in_ch0 .. i_in_ch3
//  out       o_out_valid / i_out_ready        o_out_ch0 .. o_out_ch3
//  cfg       i_cfg_wr_en (no wait)            i_cfg_index, i_cfg_wdata
//
// A pixel passes four register stages in order, ending in the output register. A new pixel
// can be transferred in every cycle in which the pipeline does not hold; the four stages are
// multiply, row sum, offset and clamp, and division by ten with the output register.
// Reset clears the stage valid bits and loads the identity matrix with no offset.
// When the output register holds a result that is not taken, the whole pipeline holds.
module color_matrix_convert #(
    parameter int CHANNELS   = cmc_pkg::DEF_CHANNELS,
    parameter int COEFF_BITS = cmc_pkg::DEF_COEFF_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [cmc_pkg::SAMPLE_BITS-1:0]   i_in_ch0,
    input  logic [cmc_pkg::SAMPLE_BITS-1:0]   i_in_ch1,
    input  logic [cmc_pkg::SAMPLE_BITS-1:0]   i_in_ch2,
    input  logic [cmc_pkg::SAMPLE_BITS-1:0]   i_in_ch3,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cmc_pkg::SAMPLE_BITS-1:0]   o_out_ch0,
    output logic [cmc_pkg::SAMPLE_BITS-1:0]   o_out_ch1,
    output logic [cmc_pkg::SAMPLE_BITS-1:0]   o_out_ch2,
    output logic [cmc_pkg::SAMPLE_BITS-1:0]   o_out_ch3,
    input  logic                              i_cfg_wr_en,
    input  logic [cmc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [cmc_pkg::REG_BITS-1:0]      i_cfg_wdata
);
    import cmc_pkg::*;

    localparam int PW = COEFF_BITS + SAMPLE_BITS + 1;
    localparam int SW = PW + 2;

    t_cfg                            w_cfg;
    logic                            w_en;
    logic [NCH-1:0][SAMPLE_BITS-1:0] w_samples;
    logic                            w_mac_valid;
    logic [NCH-1:0][SW-1:0]          w_sum;
    logic [NCH-1:0][PW-1:0]          w_offp;
    logic [NCH-1:0][SAMPLE_BITS-1:0] w_out;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_samples  = {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};

    cmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    cmc_mac #(
        .CHANNELS   (CHANNELS),
        .COEFF_BITS (COEFF_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_cfg     (w_cfg),
        .i_valid   (i_in_valid),
        .i_samples (w_samples),
        .o_valid   (w_mac_valid),
        .o_sum     (w_sum),
        .o_offp    (w_offp)
    );

    cmc_clamp #(
        .CHANNELS   (CHANNELS),
        .COEFF_BITS (COEFF_BITS)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_valid (w_mac_valid),
        .i_sum   (w_sum),
        .i_offp  (w_offp),
        .o_valid (o_out_valid),
        .o_out   (w_out)
    );

    assign o_out_ch0 = w_out[0];
    assign o_out_ch1 = w_out[1];
    assign o_out_ch2 = w_out[2];
    assign o_out_ch3 = w_out[3];

endmodule
